// File: rtl/hcbd_pkg.sv
package hcbd_pkg;

  // Default width of the chunk size and the data byte count.
  localparam int unsigned SizeBitsDef = 32;

  // Characters that steer the line parser.
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChHt   = 8'h09;

  // Decoder phase, one-hot.
  typedef enum logic [9:0] {
    PH_SIZE     = 10'b00_0000_0001,
    PH_SIZE_CR  = 10'b00_0000_0010,
    PH_DATA     = 10'b00_0000_0100,
    PH_END_CR   = 10'b00_0000_1000,
    PH_END_LF   = 10'b00_0001_0000,
    PH_TRAIL    = 10'b00_0010_0000,
    PH_TRAIL_CR = 10'b00_0100_0000,
    PH_DONE     = 10'b00_1000_0000,
    PH_ERR_SIZE = 10'b01_0000_0000,
    PH_ERR_END  = 10'b10_0000_0000
  } phase_e;

  // Status reported with every result word.
  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_END  = 2'd3
  } status_e;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    status_e    status;
  } hcbd_res_t;

endpackage

// File: rtl/hcbd_parser.sv
module hcbd_parser import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] data_byte_i,
  input  logic       body_start_i,
  output hcbd_res_t  res_o
);

  // Per-line parsing state of a size line.
  typedef struct packed {
    logic [SIZE_BITS-1:0] accum;
    logic                 digit_seen;
    logic                 hex_stopped;
    logic                 nonempty;
    logic                 overflow;
  } line_t;

  localparam logic [SIZE_BITS-1:0] One = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  phase_e               phase_q, phase_d, phase_s;
  logic [SIZE_BITS-1:0] left_q, left_d, left_s, left_dec;
  line_t                line_q, line_d, line_s, line_cr;

  // Hex digit value; the top bit flags a character that is no digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      v = 5'b1_0000;
    end
    return v;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSp) || (c >= ChHt && c <= ChCr);
  endfunction

  // One character of a size line: accumulate digits until the first stop.
  function automatic line_t size_char(line_t l, logic [7:0] c);
    line_t      r;
    logic [4:0] d;
    r = l;
    r.nonempty = 1'b1;
    d = hex_value(c);
    if (!l.hex_stopped) begin
      if (!d[4]) begin
        r.digit_seen = 1'b1;
        if (l.accum[SIZE_BITS-1 -: 4] != 4'h0) begin
          r.overflow = 1'b1;
        end
        r.accum = {l.accum[SIZE_BITS-5:0], d[3:0]};
      end else if (c == ChSemi || l.digit_seen || !is_space(c)) begin
        r.hex_stopped = 1'b1;
      end
    end
    return r;
  endfunction

  // A new body restarts the decoder before its first byte is looked at.
  always_comb begin
    phase_s  = body_start_i ? PH_SIZE : phase_q;
    left_s   = body_start_i ? '0 : left_q;
    line_s   = body_start_i ? '0 : line_q;
    left_dec = left_s - One;
    line_cr  = size_char(line_s, ChCr);
  end

  // Next state and result for the current word.
  always_comb begin
    phase_d = phase_s;
    left_d  = left_s;
    line_d  = line_s;
    res_o.out_byte  = 8'h00;
    res_o.out_valid = 1'b0;
    unique case (phase_s)
      PH_SIZE: begin
        if (data_byte_i == ChCr) begin
          phase_d = PH_SIZE_CR;
        end else begin
          line_d = size_char(line_s, data_byte_i);
        end
      end
      PH_SIZE_CR: begin
        if (data_byte_i == ChLf) begin
          if (!line_s.nonempty) begin
            line_d  = '0;
            phase_d = PH_SIZE;
          end else if (!line_s.digit_seen || line_s.overflow) begin
            phase_d = PH_ERR_SIZE;
          end else if (line_s.accum == '0) begin
            line_d  = '0;
            phase_d = PH_TRAIL;
          end else begin
            left_d  = line_s.accum;
            line_d  = '0;
            phase_d = PH_DATA;
          end
        end else if (data_byte_i == ChCr) begin
          // A lone CR is an ordinary character; the new CR may start the line end.
          line_d = line_cr;
        end else begin
          line_d  = size_char(line_cr, data_byte_i);
          phase_d = PH_SIZE;
        end
      end
      PH_DATA: begin
        res_o.out_byte  = data_byte_i;
        res_o.out_valid = 1'b1;
        left_d          = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_END_CR;
        end
      end
      PH_END_CR: begin
        phase_d = (data_byte_i == ChCr) ? PH_END_LF : PH_ERR_END;
      end
      PH_END_LF: begin
        if (data_byte_i == ChLf) begin
          line_d  = '0;
          phase_d = PH_SIZE;
        end else begin
          phase_d = PH_ERR_END;
        end
      end
      PH_TRAIL: begin
        if (data_byte_i == ChCr) begin
          phase_d = PH_TRAIL_CR;
        end else begin
          line_d.nonempty = 1'b1;
        end
      end
      PH_TRAIL_CR: begin
        if (data_byte_i == ChLf) begin
          if (!line_s.nonempty) begin
            phase_d = PH_DONE;
          end else begin
            line_d.nonempty = 1'b0;
            phase_d         = PH_TRAIL;
          end
        end else begin
          line_d.nonempty = 1'b1;
          if (data_byte_i != ChCr) begin
            phase_d = PH_TRAIL;
          end
        end
      end
      PH_DONE, PH_ERR_SIZE, PH_ERR_END: begin
      end
      default: begin
        phase_d = PH_ERR_END;
      end
    endcase

    // Status follows the phase that this word leaves behind.
    unique case (phase_d)
      PH_DONE:     res_o.status = ST_DONE;
      PH_ERR_SIZE: res_o.status = ST_BAD_SIZE;
      PH_ERR_END:  res_o.status = ST_BAD_END;
      default:     res_o.status = ST_BUSY;
    endcase
  end

  // Decoder state advances once per word handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      left_q  <= '0;
      line_q  <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      line_q  <= line_d;
    end
  end

  // The data count is never zero while data bytes are being passed.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != '0)
    else $error("data phase with zero bytes left");

  // Completion is sticky until a new body starts.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && !body_start_i && phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("complete state left without a new body");

  // A bad chunk end is sticky as well.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && !body_start_i && phase_q == PH_ERR_END |=> phase_q == PH_ERR_END)
    else $error("chunk end error cleared without a new body");

  // Data only leaves the decoder in the data phase.
  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.out_valid |-> phase_s == PH_DATA)
    else $error("data byte produced outside the data phase");

endmodule

// File: rtl/http_chunked_body_decoder.sv
// Chunked body decoder: one result word for every body byte taken in.
// Each accepted byte passes the input register and then the result register.
// Throughput: 1 byte per cycle while res_stall_i is low; the phase and count update
// of one byte is combinational between the input register and the result register.
// Reset: rst_ni is asynchronous, active low; it empties both registers and returns
// the decoder to waiting for a size line. No clearing pass is needed.
module http_chunked_body_decoder import hcbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       body_start_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic [1:0] status_o
);

  logic       ivld_q, ivld_d;
  logic [7:0] ibyte_q;
  logic       istart_q;
  logic       ovld_q, ovld_d;
  logic       advance, in_take;
  hcbd_res_t  res_s, res_q;

  // A word moves on when the result register is free or being emptied.
  assign advance    = ivld_q && (!ovld_q || !res_stall_i);
  assign in_stall_o = ivld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    ivld_d = in_take ? 1'b1 : (advance ? 1'b0 : ivld_q);
    ovld_d = advance ? 1'b1 : (ovld_q && !res_stall_i ? 1'b0 : ovld_q);
  end

  hcbd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (advance),
    .data_byte_i  (ibyte_q),
    .body_start_i (istart_q),
    .res_o        (res_s)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      ivld_q <= ivld_d;
      ovld_q <= ovld_d;
    end
  end

  // Payload of the input and result registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ibyte_q  <= data_byte_i;
      istart_q <= body_start_i;
    end
    if (advance) begin
      res_q <= res_s;
    end
  end

  assign res_valid_o = ovld_q;
  assign out_byte_o  = res_q.out_byte;
  assign out_valid_o = res_q.out_valid;
  assign status_o    = res_q.status;

  // A held input word must be stalled whenever the output is blocked.
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ivld_q && ovld_q && res_stall_i |-> in_stall_o)
    else $error("input not stalled while result is blocked");

  // A data byte is never reported together with an end status.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == ST_BUSY)
    else $error("data byte carries an end status");

  // Non-data words carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'h00)
    else $error("non-data word has a nonzero byte");

endmodule
